/* hdl/dafd_pkg.sv */
package dafd_pkg;

    // Default internal coordinate width (signed Q.24)
    localparam int DAFD_COORD_WIDTH = 32;

    // Ratio and quotient width (unsigned Q16.16)
    localparam int DAFD_RATIO_W = 32;

    // Configuration port geometry
    localparam int DAFD_AW = 6;
    localparam int DAFD_DW = 64;

    // Diagonal rotation constants, Q1.30 rounded to nearest
    localparam logic signed [31:0] DAFD_K_S23 = 32'sd876706528;  // sqrt(2/3)
    localparam logic signed [31:0] DAFD_K_S13 = 32'sd619925131;  // sqrt(1/3)
    localparam logic signed [31:0] DAFD_K_S12 = 32'sd759250125;  // sqrt(1/2)

    // Register map
    typedef enum logic [2:0] {
        REG_FOLD_OFFSET  = 3'd0,
        REG_FOLD_SCALE   = 3'd1,
        REG_EST_GAIN_OFF = 3'd2,
        REG_MODE         = 3'd3,
        REG_ROT_ROW0     = 3'd4,
        REG_ROT_ROW1     = 3'd5,
        REG_ROT_ROW2     = 3'd6
    } t_reg_idx;

    localparam logic [62:0] RST_FOLD_OFFSET  = 63'd576461027181461504;
    localparam logic [62:0] RST_FOLD_SCALE   = 63'd576461027181461504;
    localparam logic [63:0] RST_EST_GAIN_OFF = 64'd65536;
    localparam logic [1:0]  RST_MODE         = 2'd1;
    localparam logic [62:0] RST_ROT_ROW0     = 63'd65536;
    localparam logic [62:0] RST_ROT_ROW1     = 63'd137438953472;
    localparam logic [62:0] RST_ROT_ROW2     = 63'd288230376151711744;

    // Mode register bits
    localparam int MODE_EST_BIT = 0;
    localparam int MODE_ROT_BIT = 1;

    // Items carried alongside the datapath
    typedef struct packed {
        logic signed [31:0] w;
        logic [31:0]        est;
    } t_pass;

    typedef struct packed {
        logic zero;
        logic sat;
    } t_eflag;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_xyz;

    typedef struct packed {
        t_xyz        xyz;
        logic signed [31:0] w;
        logic [31:0] est;
        logic        flag;
    } t_res;

endpackage

/* hdl/dafd_isqrt.sv */
module dafd_isqrt
    import dafd_pkg::*;
#(
    parameter int IW = 2 * DAFD_COORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_rad,
    output logic [IW/2-1:0] o_root
);

    localparam int OW = IW / 2;

    logic [IW-1:0] r_rem  [OW];
    logic [OW-1:0] r_root [OW];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < OW; k++) begin : g_stage
        localparam int B = OW - 1 - k;
        logic [IW-1:0] rem_in;
        logic [OW-1:0] root_in;
        logic [IW-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (r + 2^B)^2 - r^2
        assign trial = (IW'(root_in) << (B + 1)) | (IW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (OW'(1) << B);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

/* hdl/dafd_div.sv */
module dafd_div
    import dafd_pkg::*;
#(
    parameter int NW = DAFD_COORD_WIDTH + 16,
    parameter int DW = DAFD_COORD_WIDTH,
    parameter int QW = DAFD_RATIO_W
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int XW = DW + QW;

    logic [XW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [XW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [XW-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = XW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = XW'(den_in) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_in;
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_quo[k] <= quo_in | (QW'(1) << B);
                end else begin
                    r_rem[k] <= rem_in;
                    r_quo[k] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* hdl/diagonal_abs_fold_transform_unit.sv */
// Accepted transactions pass through the pipeline stages and the output register to o_valid.
// Throughput: one transaction per cycle while o_stall is low; the length roots (one bit
// per stage) and the ratio divider (one quotient bit per stage) set the depth, not the rate.
// A two-entry output register and skid keep input acceptance off the output stall.
// Reset (i_rst_n low, synchronous) empties the pipeline and reloads every configuration
// register with its reset value; payload registers are not cleared.
module diagonal_abs_fold_transform_unit
    import dafd_pkg::*;
#(
    parameter int COORD_WIDTH = DAFD_COORD_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    input  logic signed [31:0]  i_in_w,
    input  logic [31:0]         i_in_estimate,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic [31:0]         o_out_estimate,
    output logic                o_estimate_flag,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [DAFD_AW-1:0]  paddr,
    input  logic [DAFD_DW-1:0]  pwdata,
    output logic [DAFD_DW-1:0]  prdata,
    output logic                pready
);

    localparam int CW     = COORD_WIDTH;
    localparam int PW     = CW + 34;
    localparam int SW     = 2 * CW;
    localparam int QW     = DAFD_RATIO_W;
    localparam int NW     = CW + 16;
    localparam int ST_E1  = 10 + CW;
    localparam int LAT    = ST_E1 + QW + 4;
    localparam int DP     = LAT - 1;
    localparam int XD     = LAT - 14;

    localparam logic signed [PW-1:0] C_HI = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [PW-1:0] C_LO = ~C_HI;
    localparam logic signed [PW-1:0] O_HI = PW'(33'sh07FFFFFFF);
    localparam logic signed [PW-1:0] O_LO = PW'(33'sh180000000);

    // ---------------------------------------------------------------- arithmetic helpers

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [PW-1:0] v);
        if (v > C_HI) return C_HI[CW-1:0];
        if (v < C_LO) return C_LO[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
        logic signed [PW-1:0] e;
        e = PW'(v);
        if (e > O_HI) return O_HI[31:0];
        if (e < O_LO) return O_LO[31:0];
        return e[31:0];
    endfunction

    function automatic logic signed [CW-1:0] sadd(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return sat_cw(PW'(a) + PW'(b));
    endfunction

    function automatic logic signed [CW-1:0] ssub(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return sat_cw(PW'(a) - PW'(b));
    endfunction

    function automatic logic signed [CW-1:0] sabs(input logic signed [CW-1:0] v);
        return v[CW-1] ? sat_cw(-PW'(v)) : v;
    endfunction

    // product shifted back, truncated toward zero, saturated
    function automatic logic signed [CW-1:0] mulc(input logic signed [CW-1:0] a,
                                                   input logic signed [31:0]   c,
                                                   input int unsigned          sh);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = PW'(a) * PW'(c);
        if (p < 0) q = -((-p) >>> sh);
        else       q = p >>> sh;
        return sat_cw(q);
    endfunction

    function automatic logic signed [31:0] fld(input logic [62:0] r, input int k);
        return 32'($signed(r[21*k +: 21]));
    endfunction

    function automatic logic [SW-1:0] sq(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return SW'(m) * SW'(m);
    endfunction

    // ---------------------------------------------------------------- configuration

    logic [62:0]  r_cfg_off;
    logic [62:0]  r_cfg_scl;
    logic [63:0]  r_cfg_est;
    logic [1:0]   r_cfg_mode;
    logic [62:0]  r_rot [3];
    t_reg_idx     w_idx;
    logic         w_wr;

    assign w_idx  = t_reg_idx'(paddr[DAFD_AW-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= RST_FOLD_OFFSET;
            r_cfg_scl  <= RST_FOLD_SCALE;
            r_cfg_est  <= RST_EST_GAIN_OFF;
            r_cfg_mode <= RST_MODE;
            r_rot[0]   <= RST_ROT_ROW0;
            r_rot[1]   <= RST_ROT_ROW1;
            r_rot[2]   <= RST_ROT_ROW2;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FOLD_OFFSET:  r_cfg_off  <= pwdata[62:0];
                REG_FOLD_SCALE:   r_cfg_scl  <= pwdata[62:0];
                REG_EST_GAIN_OFF: r_cfg_est  <= pwdata;
                REG_MODE:         r_cfg_mode <= pwdata[1:0];
                REG_ROT_ROW0:     r_rot[0]   <= pwdata[62:0];
                REG_ROT_ROW1:     r_rot[1]   <= pwdata[62:0];
                REG_ROT_ROW2:     r_rot[2]   <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_FOLD_OFFSET:  prdata = {1'b0, r_cfg_off};
            REG_FOLD_SCALE:   prdata = {1'b0, r_cfg_scl};
            REG_EST_GAIN_OFF: prdata = r_cfg_est;
            REG_MODE:         prdata = {62'd0, r_cfg_mode};
            REG_ROT_ROW0:     prdata = {1'b0, r_rot[0]};
            REG_ROT_ROW1:     prdata = {1'b0, r_rot[1]};
            REG_ROT_ROW2:     prdata = {1'b0, r_rot[2]};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- pipeline control

    logic            en;
    logic [LAT-1:0]  r_vld;
    logic            r_out_v;
    logic            r_skid_v;
    logic            take;
    t_res            r_out;
    t_res            r_skid;
    t_res            w_fin;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign take    = r_out_v && !i_stall;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------- forward rotation and fold

    logic signed [CW-1:0] w_cx, w_cy, w_cz;
    logic signed [CW-1:0] r1_x23, r1_z13, r1_x13, r1_z23, r1_y;
    logic signed [CW-1:0] r2_a, r2_pz, r2_y;
    logic signed [CW-1:0] r3_dm, r3_dp, r3_pz;
    logic signed [CW-1:0] r4_px, r4_py, r4_pz;
    logic signed [CW-1:0] r5_t [3];
    logic signed [CW-1:0] r6_d [3];
    logic signed [CW-1:0] r6_t [3];
    logic signed [CW-1:0] r7_f [3];
    logic signed [CW-1:0] r7_t [3];
    logic [SW-1:0]        r8_st [3];
    logic [SW-1:0]        r8_sf [3];
    logic signed [CW-1:0] r8_m [3][3];
    logic signed [CW-1:0] r8_f [3];
    logic [SW-1:0]        r9_sumt, r9_sumf;
    logic signed [CW-1:0] r9_g [3];
    logic signed [CW-1:0] r10_gs, r10_gd, r10_g2;
    logic signed [CW-1:0] r11_a, r11_py, r11_g2;
    logic signed [CW-1:0] r12_m [4];
    logic signed [CW-1:0] r12_py;
    t_xyz                 r13_xyz;

    assign w_cx = sat_cw(PW'(i_in_x));
    assign w_cy = sat_cw(PW'(i_in_y));
    assign w_cz = sat_cw(PW'(i_in_z));

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rotate onto the diagonal
            r1_x23 <= mulc(w_cx, DAFD_K_S23, 30);
            r1_z13 <= mulc(w_cz, DAFD_K_S13, 30);
            r1_x13 <= mulc(w_cx, DAFD_K_S13, 30);
            r1_z23 <= mulc(w_cz, DAFD_K_S23, 30);
            r1_y   <= w_cy;

            r2_a   <= ssub(r1_x23, r1_z13);
            r2_pz  <= sadd(r1_x13, r1_z23);
            r2_y   <= r1_y;

            r3_dm  <= ssub(r2_a, r2_y);
            r3_dp  <= sadd(r2_a, r2_y);
            r3_pz  <= r2_pz;

            r4_px  <= mulc(r3_dm, DAFD_K_S12, 30);
            r4_py  <= mulc(r3_dp, DAFD_K_S12, 30);
            r4_pz  <= r3_pz;

            // swap each axis for the sum of the other two
            r5_t[0] <= sadd(r4_py, r4_pz);
            r5_t[1] <= sadd(r4_px, r4_pz);
            r5_t[2] <= sadd(r4_px, r4_py);

            // offset, fold, scale
            for (int i = 0; i < 3; i++) begin
                r6_d[i] <= sabs(sat_cw(PW'(r5_t[i]) - (PW'(fld(r_cfg_off, i)) <<< 8)));
                r6_t[i] <= r5_t[i];
                r7_f[i] <= mulc(r6_d[i], fld(r_cfg_scl, i), 16);
                r7_t[i] <= r6_t[i];
            end

            // squares for the lengths, products for the optional rotation
            for (int i = 0; i < 3; i++) begin
                r8_st[i] <= sq(r7_t[i]);
                r8_sf[i] <= sq(r7_f[i]);
                r8_f[i]  <= r7_f[i];
                for (int j = 0; j < 3; j++) begin
                    r8_m[i][j] <= mulc(r7_f[j], fld(r_rot[i], j), 16);
                end
            end

            r9_sumt <= r8_st[0] + r8_st[1] + r8_st[2];
            r9_sumf <= r8_sf[0] + r8_sf[1] + r8_sf[2];
            for (int i = 0; i < 3; i++) begin
                if (r_cfg_mode[MODE_ROT_BIT]) begin
                    r9_g[i] <= sadd(sadd(r8_m[i][0], r8_m[i][1]), r8_m[i][2]);
                end else begin
                    r9_g[i] <= r8_f[i];
                end
            end

            // inverse diagonal rotation
            r10_gs <= sadd(r9_g[1], r9_g[0]);
            r10_gd <= ssub(r9_g[1], r9_g[0]);
            r10_g2 <= r9_g[2];

            r11_a  <= mulc(r10_gs, DAFD_K_S12, 30);
            r11_py <= mulc(r10_gd, DAFD_K_S12, 30);
            r11_g2 <= r10_g2;

            r12_m[0] <= mulc(r11_g2, DAFD_K_S13, 30);
            r12_m[1] <= mulc(r11_a,  DAFD_K_S23, 30);
            r12_m[2] <= mulc(r11_g2, DAFD_K_S23, 30);
            r12_m[3] <= mulc(r11_a,  DAFD_K_S13, 30);
            r12_py   <= r11_py;

            r13_xyz.x <= sat32(sadd(r12_m[0], r12_m[1]));
            r13_xyz.y <= sat32(r12_py);
            r13_xyz.z <= sat32(ssub(r12_m[2], r12_m[3]));
        end
    end

    // ---------------------------------------------------------------- delay lines

    t_pass  r_pass    [DP];
    t_xyz   r_xyz_dly [XD];
    t_eflag r_fl_dly  [QW];
    t_eflag r_e1_fl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pass[0].w   <= i_in_w;
            r_pass[0].est <= i_in_estimate;
            for (int k = 1; k < DP; k++) r_pass[k] <= r_pass[k-1];
            r_xyz_dly[0] <= r13_xyz;
            for (int k = 1; k < XD; k++) r_xyz_dly[k] <= r_xyz_dly[k-1];
            r_fl_dly[0] <= r_e1_fl;
            for (int k = 1; k < QW; k++) r_fl_dly[k] <= r_fl_dly[k-1];
        end
    end

    // ---------------------------------------------------------------- lengths and ratio

    logic [CW-1:0] w_lt, w_lf;
    logic [NW-1:0] r_e1_num;
    logic [CW-1:0] r_e1_den;
    logic [QW-1:0] w_quo;

    dafd_isqrt #(.IW(SW)) u_len_t (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r9_sumt),
        .o_root (w_lt)
    );

    dafd_isqrt #(.IW(SW)) u_len_f (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r9_sumf),
        .o_root (w_lf)
    );

    // Flag zero divisor and ratio overflow, set up the division
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_num      <= {w_lf, 16'h0};
            r_e1_den      <= w_lt;
            r_e1_fl.zero  <= (w_lt == '0);
            r_e1_fl.sat   <= ({w_lt, 16'h0} <= NW'(w_lf));
        end
    end

    dafd_div #(.NW(NW), .DW(CW), .QW(QW)) u_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_e1_num),
        .i_den (r_e1_den),
        .o_quo (w_quo)
    );

    // ---------------------------------------------------------------- estimate update

    logic [QW-1:0]        w_ratio;
    logic [63:0]          w_eprod;
    logic signed [31:0]   w_gain;
    logic [31:0]          w_gmag;
    logic [79:0]          w_psum;
    logic signed [65:0]   w_esum;
    logic [47:0]          r_e2_val;
    t_eflag               r_e2_fl;
    logic [63:0]          r_e3_lo;
    logic [47:0]          r_e3_hi;
    t_eflag               r_e3_fl;
    logic signed [65:0]   r_e4_val;
    t_eflag               r_e4_fl;

    assign w_ratio = r_fl_dly[QW-1].sat ? '1 : w_quo;
    assign w_eprod = 64'(r_pass[ST_E1+QW-1].est) * 64'(w_ratio);
    assign w_gain  = $signed(r_cfg_est[31:0]);
    assign w_gmag  = w_gain[31] ? 32'(-w_gain) : 32'(w_gain);
    assign w_psum  = 80'(r_e3_lo) + {r_e3_hi, 32'h0};
    assign w_esum  = r_e4_val + 66'($signed(r_cfg_est[63:32]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            // scale by the length ratio
            r_e2_val <= w_eprod[63:16];
            r_e2_fl  <= r_fl_dly[QW-1];

            // gain as two partial products
            r_e3_lo  <= 64'(r_e2_val[31:0]) * 64'(w_gmag);
            r_e3_hi  <= 48'(r_e2_val[47:32]) * 48'(w_gmag);
            r_e3_fl  <= r_e2_fl;

            // shift back, restore sign
            r_e4_val <= w_gain[31] ? -$signed({2'b00, w_psum[79:16]})
                                   :  $signed({2'b00, w_psum[79:16]});
            r_e4_fl  <= r_e3_fl;
        end
    end

    // Final stage: add offset, clamp, pick the estimate
    always_ff @(posedge i_clk) begin
        if (en) begin
            w_fin.xyz <= r_xyz_dly[XD-1];
            w_fin.w   <= r_pass[LAT-2].w;
            if (!r_cfg_mode[MODE_EST_BIT]) begin
                w_fin.est  <= r_pass[LAT-2].est;
                w_fin.flag <= 1'b0;
            end else if (r_e4_fl.zero) begin
                w_fin.est  <= r_pass[LAT-2].est;
                w_fin.flag <= 1'b1;
            end else if (w_esum < 0) begin
                w_fin.est  <= '0;
                w_fin.flag <= 1'b1;
            end else if (w_esum > 66'sh0FFFFFFFF) begin
                w_fin.est  <= '1;
                w_fin.flag <= 1'b1;
            end else begin
                w_fin.est  <= w_esum[31:0];
                w_fin.flag <= r_e4_fl.sat;
            end
        end
    end

    // ---------------------------------------------------------------- output register and skid

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) r_skid_v <= 1'b0;
        end else if (r_vld[LAT-1]) begin
            if (!r_out_v || take) r_out_v  <= 1'b1;
            else                  r_skid_v <= 1'b1;
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) r_out <= r_skid;
        end else if (r_vld[LAT-1] && (!r_out_v || take)) begin
            r_out <= w_fin;
        end else if (r_vld[LAT-1]) begin
            r_skid <= w_fin;
        end
    end

    assign o_valid         = r_out_v;
    assign o_out_x         = r_out.xyz.x;
    assign o_out_y         = r_out.xyz.y;
    assign o_out_z         = r_out.xyz.z;
    assign o_out_w         = r_out.w;
    assign o_out_estimate  = r_out.est;
    assign o_estimate_flag = r_out.flag;

    // ---------------------------------------------------------------- assertions

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds a transaction while the output register is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction missing from the first stage");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled without a stalled output");

endmodule

/* dv/tb_diagonal_abs_fold_transform_unit.sv */
module tb_diagonal_abs_fold_transform_unit;
    import dafd_pkg::*;

    localparam int        CYCLE_LIMIT = 600000;
    localparam int        DRAIN_WAIT  = 120;
    localparam logic [63:0] MASK_VEC  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK_MODE = 64'd3;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic [31:0]        est;
    } t_point;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_in_x, i_in_y, i_in_z, i_in_w;
    logic [31:0]        i_in_estimate;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic [31:0]        o_out_estimate;
    logic               o_estimate_flag;
    logic               psel, penable, pwrite;
    logic [DAFD_AW-1:0] paddr;
    logic [DAFD_DW-1:0] pwdata;
    logic [DAFD_DW-1:0] prdata;
    logic               pready;

    // Shadow copy of the register file and the queue of predicted results
    logic [63:0] cfg_shadow [7];
    t_res        expected_results [$];
    int          n_fail;
    int          burst_left;
    longint      cycle_count;

    diagonal_abs_fold_transform_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_x         (i_in_x),
        .i_in_y         (i_in_y),
        .i_in_z         (i_in_z),
        .i_in_w         (i_in_w),
        .i_in_estimate  (i_in_estimate),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_w        (o_out_w),
        .o_out_estimate (o_out_estimate),
        .o_estimate_flag(o_estimate_flag),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------------
    // Fixed-point helpers
    // ---------------------------------------------------------------------

    // Signed product shifted right, truncated toward zero
    function automatic logic signed [127:0] mul_shift(longint a, longint b, int sh);
        logic signed [127:0] wa, wb, p;
        logic [127:0]        m;
        wa = a;
        wb = b;
        p  = wa * wb;
        m  = p[127] ? -p : p;
        m  = m >> sh;
        return p[127] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to a signed 32-bit Q.24 coordinate
    function automatic longint clamp_q24(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 64'sd2147483647;
        if (v < -128'sd2147483648) return -64'sd2147483648;
        return longint'(v);
    endfunction

    function automatic longint mul_rot(longint v, longint k);
        return clamp_q24(mul_shift(v, k, 30));
    endfunction

    function automatic longint mul_q16(longint v, longint k);
        return clamp_q24(mul_shift(v, k, 16));
    endfunction

    function automatic longint q416_field(logic [63:0] r, int k);
        logic signed [20:0] f;
        f = r[21*k +: 21];
        return longint'(f);
    endfunction

    // Floor square root of the exact sum of squares
    function automatic logic [63:0] vec_len(longint v0, longint v1, longint v2);
        logic signed [127:0] w0, w1, w2;
        logic [127:0]        s, t;
        logic [63:0]         r;
        w0 = v0;
        w1 = v1;
        w2 = v2;
        s  = $unsigned(w0 * w0) + $unsigned(w1 * w1) + $unsigned(w2 * w2);
        r  = '0;
        for (int b = 63; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= s) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // Full transform of one point under the shadow configuration
    function automatic t_res fold_point(t_point p);
        t_res                r;
        longint              x, y, z, a, px, py, pz, d;
        longint              t [3];
        longint              f [3];
        longint              g [3];
        longint              s23, s13, s12;
        logic [63:0]         lt, lf, ratio, ep;
        logic [127:0]        num;
        logic signed [127:0] e;
        logic                flag;
        logic [31:0]         est;
        s23  = DAFD_K_S23;
        s13  = DAFD_K_S13;
        s12  = DAFD_K_S12;
        x    = p.x;
        y    = p.y;
        z    = p.z;
        est  = p.est;
        flag = 1'b0;

        // Rotate onto the diagonal
        a  = clamp_q24(mul_rot(x, s23) - mul_rot(z, s13));
        px = mul_rot(clamp_q24(a - y), s12);
        py = mul_rot(clamp_q24(a + y), s12);
        pz = clamp_q24(mul_rot(x, s13) + mul_rot(z, s23));

        // Sum of the other two axes, then offset, fold and scale
        t[0] = clamp_q24(py + pz);
        t[1] = clamp_q24(px + pz);
        t[2] = clamp_q24(px + py);
        for (int i = 0; i < 3; i++) begin
            d = clamp_q24(t[i] - q416_field(cfg_shadow[REG_FOLD_OFFSET], i) * 256);
            if (d < 0) d = clamp_q24(-d);
            f[i] = mul_q16(d, q416_field(cfg_shadow[REG_FOLD_SCALE], i));
        end

        // Estimate update from the length ratio
        if (cfg_shadow[REG_MODE][MODE_EST_BIT]) begin
            lt = vec_len(t[0], t[1], t[2]);
            lf = vec_len(f[0], f[1], f[2]);
            if (lt == 0) begin
                flag = 1'b1;
            end else begin
                num = {64'd0, lf} << 16;
                if (({64'd0, lt} << 32) <= num) begin
                    ratio = 64'hFFFF_FFFF;
                    flag  = 1'b1;
                end else begin
                    ratio = 64'(num / {64'd0, lt});
                end
                ep = {32'd0, est} * ratio;
                e  = mul_shift(longint'(ep >> 16),
                               longint'($signed(cfg_shadow[REG_EST_GAIN_OFF][31:0])), 16);
                e  = e + longint'($signed(cfg_shadow[REG_EST_GAIN_OFF][63:32]));
                if (e < 0) begin
                    e    = 0;
                    flag = 1'b1;
                end
                if (e > 128'sh0_FFFF_FFFF) begin
                    e    = 128'sh0_FFFF_FFFF;
                    flag = 1'b1;
                end
                est = e[31:0];
            end
        end

        // Optional configured rotation
        for (int i = 0; i < 3; i++) begin
            if (cfg_shadow[REG_MODE][MODE_ROT_BIT]) begin
                g[i] = mul_q16(f[0], q416_field(cfg_shadow[REG_ROT_ROW0 + i], 0));
                g[i] = clamp_q24(g[i] + mul_q16(f[1], q416_field(cfg_shadow[REG_ROT_ROW0 + i], 1)));
                g[i] = clamp_q24(g[i] + mul_q16(f[2], q416_field(cfg_shadow[REG_ROT_ROW0 + i], 2)));
            end else begin
                g[i] = f[i];
            end
        end

        // Inverse diagonal rotation
        a  = mul_rot(clamp_q24(g[1] + g[0]), s12);
        px = clamp_q24(mul_rot(g[2], s13) + mul_rot(a, s23));
        py = mul_rot(clamp_q24(g[1] - g[0]), s12);
        pz = clamp_q24(mul_rot(g[2], s23) - mul_rot(a, s13));

        r.xyz.x = px[31:0];
        r.xyz.y = py[31:0];
        r.xyz.z = pz[31:0];
        r.w     = p.w;
        r.est   = est;
        r.flag  = flag;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus generators
    // ---------------------------------------------------------------------

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            2:       return 32'($signed($urandom_range(0, 2047)) - 32'sd1024);
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4:       return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        p.w = $urandom;
        case ($urandom_range(0, 3))
            0:       p.est = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            1:       p.est = $urandom_range(0, 32'h0010_0000);
            default: p.est = $urandom;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] rand_vec21();
        logic [63:0] v;
        logic [20:0] f;
        v = '0;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0:       f = 21'h0F_FFFF;
                1:       f = 21'h10_0000;
                2:       f = 21'h00_0000;
                3:       f = 21'(32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000));
                default: f = $urandom;
            endcase
            v[21*k +: 21] = f;
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_gain_offset();
        logic [31:0] gain, offs;
        case ($urandom_range(0, 4))
            0:       gain = 32'h0001_0000;
            1:       gain = 32'h7FFF_FFFF;
            2:       gain = 32'h8000_0000;
            3:       gain = $urandom_range(0, 32'h0004_0000);
            default: gain = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       offs = 32'd0;
            1:       offs = 32'h7FFF_FFFF;
            2:       offs = 32'h8000_0000;
            3:       offs = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            default: offs = $urandom;
        endcase
        return {offs, gain};
    endfunction

    // ---------------------------------------------------------------------
    // Bus and stream tasks
    // ---------------------------------------------------------------------

    // Two-phase register write; the register takes the data on the access edge
    task automatic reg_write(t_reg_idx idx, logic [63:0] value);
        logic [63:0] masked;
        masked  = value & ((idx == REG_MODE) ? MASK_MODE :
                           (idx == REG_EST_GAIN_OFF) ? 64'hFFFF_FFFF_FFFF_FFFF : MASK_VEC);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DAFD_AW'(int'(idx) * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow[idx] = masked;
    endtask

    // Drive one point, hold it until accepted, and record its prediction
    task automatic send_point(t_point p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && i_valid) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_in_x        <= p.x;
        i_in_y        <= p.y;
        i_in_z        <= p.z;
        i_in_w        <= p.w;
        i_in_estimate <= p.est;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(fold_point(p));
        burst_left--;
    endtask

    // Drop valid and wait for the pipeline to empty before touching registers
    task automatic drain_pipeline();
        i_valid   <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w, logic [31:0] est);
        t_point p;
        p.x   = x;
        p.y   = y;
        p.z   = z;
        p.w   = w;
        p.est = est;
        send_point(p);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset configuration: origin (zero divisor), coordinate and estimate extremes
    task automatic test_reset_config();
        send_xyz(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h0001_0000);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        send_xyz(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 32'h1234_5678, 32'h0002_8000);
        drain_pipeline();
    endtask

    // Tiny but non-zero diagonal lengths push the ratio past its range
    task automatic test_ratio_saturation();
        send_xyz(32'd64, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_xyz(32'd1, 32'd0, 32'd0, 32'd2, 32'h0001_0000);
        send_xyz(32'd0, 32'd256, 32'd0, 32'd3, 32'h0100_0000);
        send_xyz(32'hFFFF_FF00, 32'd5, 32'd9, 32'd4, 32'h0000_8000);
        drain_pipeline();
    endtask

    // Negative gain clamps to zero, maximum gain and offset clamp high
    task automatic test_estimate_clamp();
        reg_write(REG_EST_GAIN_OFF, {32'd0, 32'h8000_0000});
        send_xyz(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'd5, 32'h0010_0000);
        send_xyz(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'd6, 32'd0);
        drain_pipeline();
        reg_write(REG_EST_GAIN_OFF, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_xyz(32'h0100_0000, 32'hFF00_0000, 32'h0040_0000, 32'd7, 32'hFFFF_FFFF);
        send_xyz(32'd0, 32'd0, 32'd0, 32'd8, 32'h0000_1000);
        drain_pipeline();
    endtask

    // Estimate off, then extra rotation on with extreme matrix rows
    task automatic test_mode_extremes();
        reg_write(REG_MODE, 64'd0);
        send_xyz(32'd0, 32'd0, 32'd0, 32'd9, 32'hDEAD_BEEF);
        send_xyz(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd10, 32'h0001_0000);
        drain_pipeline();
        reg_write(REG_MODE, 64'd3);
        reg_write(REG_ROT_ROW0, MASK_VEC);
        reg_write(REG_ROT_ROW1, {1'b0, 21'h0F_FFFF, 21'h0F_FFFF, 21'h0F_FFFF});
        reg_write(REG_ROT_ROW2, {1'b0, 21'h10_0000, 21'h10_0000, 21'h10_0000});
        reg_write(REG_FOLD_OFFSET, {1'b0, 21'h0F_FFFF, 21'h10_0000, 21'h00_0000});
        reg_write(REG_FOLD_SCALE, {1'b0, 21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF});
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd11, 32'hFFFF_FFFF);
        send_xyz(32'h8000_0000, 32'h0100_0000, 32'd0, 32'd12, 32'h0001_0000);
        send_xyz(32'd0, 32'd0, 32'd0, 32'd13, 32'h0000_0000);
        drain_pipeline();
    endtask

    // Random configuration phases, each followed by a run of random points
    task automatic test_random_phases(int n_phases, int points_per_phase);
        for (int ph = 0; ph < n_phases; ph++) begin
            case (ph % 4)
                0: begin
                    reg_write(REG_FOLD_OFFSET, 64'd0);
                    reg_write(REG_FOLD_SCALE, MASK_VEC);
                end
                1: begin
                    reg_write(REG_FOLD_OFFSET, MASK_VEC);
                    reg_write(REG_FOLD_SCALE, 64'd0);
                end
                default: begin
                    reg_write(REG_FOLD_OFFSET, rand_vec21());
                    reg_write(REG_FOLD_SCALE, rand_vec21());
                end
            endcase
            reg_write(REG_EST_GAIN_OFF, (ph == 1) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                        (ph == 2) ? 64'd0 : rand_gain_offset());
            reg_write(REG_MODE, 64'(ph % 4));
            reg_write(REG_ROT_ROW0, rand_vec21());
            reg_write(REG_ROT_ROW1, rand_vec21());
            reg_write(REG_ROT_ROW2, rand_vec21());
            for (int n = 0; n < points_per_phase; n++) send_point(rand_point());
            drain_pipeline();
        end
    endtask

    // ---------------------------------------------------------------------
    // Result checking and output stall pattern
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_res exp_res;
        int   phase;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: x=%h est=%h", o_out_x, o_out_estimate);
                n_fail++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_x !== exp_res.xyz.x) begin
                    $error("out_x: expected %h, got %h", exp_res.xyz.x, o_out_x);
                    n_fail++;
                end
                if (o_out_y !== exp_res.xyz.y) begin
                    $error("out_y: expected %h, got %h", exp_res.xyz.y, o_out_y);
                    n_fail++;
                end
                if (o_out_z !== exp_res.xyz.z) begin
                    $error("out_z: expected %h, got %h", exp_res.xyz.z, o_out_z);
                    n_fail++;
                end
                if (o_out_w !== exp_res.w) begin
                    $error("out_w: expected %h, got %h", exp_res.w, o_out_w);
                    n_fail++;
                end
                if (o_out_estimate !== exp_res.est) begin
                    $error("out_estimate: expected %h, got %h", exp_res.est, o_out_estimate);
                    n_fail++;
                end
                if (o_estimate_flag !== exp_res.flag) begin
                    $error("estimate_flag: expected %b, got %b", exp_res.flag, o_estimate_flag);
                    n_fail++;
                end
            end
        end

        // Rotate through free-running, light, heavy and periodic stalling
        phase = int'((cycle_count >> 9) % 4);
        case (phase)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (cycle_count[2:0] < 3'd3);
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_in_x        = '0;
        i_in_y        = '0;
        i_in_z        = '0;
        i_in_w        = '0;
        i_in_estimate = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        n_fail        = 0;
        burst_left    = 0;
        cycle_count   = 0;
        cfg_shadow[REG_FOLD_OFFSET]  = 64'(RST_FOLD_OFFSET);
        cfg_shadow[REG_FOLD_SCALE]   = 64'(RST_FOLD_SCALE);
        cfg_shadow[REG_EST_GAIN_OFF] = RST_EST_GAIN_OFF;
        cfg_shadow[REG_MODE]         = 64'(RST_MODE);
        cfg_shadow[REG_ROT_ROW0]     = 64'(RST_ROT_ROW0);
        cfg_shadow[REG_ROT_ROW1]     = 64'(RST_ROT_ROW1);
        cfg_shadow[REG_ROT_ROW2]     = 64'(RST_ROT_ROW2);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_ratio_saturation();
        test_estimate_clamp();
        test_mode_extremes();
        test_random_phases(8, 130);

        drain_pipeline();
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/dafd_pkg.sv
hdl/dafd_isqrt.sv
hdl/dafd_div.sv
hdl/diagonal_abs_fold_transform_unit.sv
dv/tb_diagonal_abs_fold_transform_unit.sv
